FILE: hw/rtl/rgb_luma_histogram_assert.svh
// assertion macros for the luma histogram rtl
`ifndef RGB_LUMA_HISTOGRAM_ASSERT_SVH
`define RGB_LUMA_HISTOGRAM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RLH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlh assertion failed");

// next-cycle implication, checked outside reset
`define RLH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlh assertion failed");

`endif

FILE: hw/rtl/rlh_pkg.sv
// types, constants and helpers for the luma histogram
`default_nettype none

package rlh_pkg;

    // storage
    localparam int MAX_BINS    = 256;
    localparam int COUNT_WIDTH = 32;
    localparam int BIN_W       = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    // fixed field widths
    localparam int COMP_W      = 8;
    localparam int WEIGHT_W    = 16;
    localparam int LEVELS_W    = 9;
    localparam int SEL_W       = 8;
    localparam int CMD_W       = 2;
    localparam int OUT_COUNT_W = 32;
    localparam int PROD_W      = COMP_W + WEIGHT_W;
    localparam int SUM_W       = PROD_W + 2;

    // gray scaling: bin = floor(sum * (levels - 1) / (255 * 2^16))
    localparam int FRAC_W      = 16;
    localparam int SCALED_W    = SUM_W + BIN_W;
    localparam int Y_W         = SCALED_W - FRAC_W;
    localparam int Q_W         = Y_W - 7;
    localparam int GRAY_DIV    = 255;
    localparam int RECIP       = 257;
    localparam int RECIP_SHIFT = 16;

    // stream words
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 40;

    // config port
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // result queue
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;
    localparam int OCC_W       = FIFO_CNT_W + 1;

    // register reset values
    localparam logic [LEVELS_W-1:0] LEVELS_RESET = 9'd256;
    localparam logic [WEIGHT_W-1:0] WRED_RESET   = 16'd19595;
    localparam logic [WEIGHT_W-1:0] WGREEN_RESET = 16'd38470;
    localparam logic [WEIGHT_W-1:0] WBLUE_RESET  = 16'd7471;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD        = 2'd0,
        CMD_READ       = 2'd1,
        CMD_READ_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_LEVELS       = 2'd0,
        REG_WEIGHT_RED   = 2'd1,
        REG_WEIGHT_GREEN = 2'd2,
        REG_WEIGHT_BLUE  = 2'd3
    } reg_index_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [BIN_W-1:0]       bin_t;

    // clip a counter to the 32-bit result field
    function automatic logic [OUT_COUNT_W-1:0] clip_count(input count_t c);
        logic [OUT_COUNT_W-1:0] r;
        begin
            r = OUT_COUNT_W'(c);
            if ((COUNT_WIDTH > OUT_COUNT_W) && ((c >> OUT_COUNT_W) != '0))
            begin
                r = '1;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rgb_luma_histogram.sv
// luma histogram: pixel to gray bin, counter memory with read and read-clear
// usage
//   s_* stream: one word per command. s_tuser carries the command (add pixel,
//   read bin, read and clear bin). add words carry red, green and blue in
//   s_tdata and produce no result; read words carry bin_select and produce
//   exactly one result word on the m_* stream (bin number and its count).
//   apb port: levels_in_use and three q0.16 gray weights, written while idle.
// timing
//   a six-stage pipeline: input register, three weight products, scaling by
//   levels-1, reciprocal divide by 255, correction and clamp with the memory
//   read, then the read-modify-write of the counter. a result word is pushed
//   into the result queue from the last stage. one word per cycle is
//   accepted when not stalled; the dual-port counter ram takes one read
//   and one write per cycle, and back-to-back hits on one bin are forwarded.
// stall
//   results wait in an 8-word queue; s_tready drops when queued plus
//   in-flight words fill it, so nothing is ever dropped.
// reset
//   valid flags cleared at reset make every counter read as zero, so words are
//   taken from the first cycle; levels go to 256 and the weights to bt.601
`default_nettype none

`include "rgb_luma_histogram_assert.svh"

module rgb_luma_histogram
    import rlh_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    // command stream
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [S_DATA_W-1:0]    s_tdata,   // red, green, blue, bin_select
    input  wire  [CMD_W-1:0]       s_tuser,   // command
    // result stream
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [M_DATA_W-1:0]    m_tdata,   // bin_number, bin_count
    // config port
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [APB_ADDR_W-1:0]  paddr,
    input  wire  [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [LEVELS_W-1:0] levels_reg;
    logic [WEIGHT_W-1:0] wred_reg;
    logic [WEIGHT_W-1:0] wgreen_reg;
    logic [WEIGHT_W-1:0] wblue_reg;
    reg_index_t          reg_sel;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= LEVELS_RESET;
            wred_reg   <= WRED_RESET;
            wgreen_reg <= WGREEN_RESET;
            wblue_reg  <= WBLUE_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_LEVELS:       levels_reg <= pwdata[LEVELS_W-1:0];
                REG_WEIGHT_RED:   wred_reg   <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_GREEN: wgreen_reg <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_BLUE:  wblue_reg  <= pwdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_LEVELS:       prdata = APB_DATA_W'(levels_reg);
            REG_WEIGHT_RED:   prdata = APB_DATA_W'(wred_reg);
            REG_WEIGHT_GREEN: prdata = APB_DATA_W'(wgreen_reg);
            REG_WEIGHT_BLUE:  prdata = APB_DATA_W'(wblue_reg);
            default:          prdata = '0;
        endcase
    end

    // top bin index in use: zero levels act as one, too many as MAX_BINS
    bin_t top_bin;

    always_comb
    begin
        if (levels_reg == '0)
        begin
            top_bin = '0;
        end
        else if (int'(levels_reg) > MAX_BINS)
        begin
            top_bin = BIN_W'(MAX_BINS - 1);
        end
        else
        begin
            top_bin = BIN_W'(levels_reg - LEVELS_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // result queue bookkeeping and input credit
    // ------------------------------------------------------------------
    logic [FIFO_CNT_W-1:0] fifo_count_reg;
    logic [FIFO_CNT_W-1:0] fifo_count_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [M_DATA_W-1:0]   fifo_mem [FIFO_DEPTH];
    logic                  fifo_push;
    logic                  fifo_pop;
    logic [M_DATA_W-1:0]   fifo_wdata;
    logic [OCC_W-1:0]      occupancy;
    logic [OCC_W-1:0]      inflight;

    logic p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic p4_valid_reg, p5_valid_reg, p6_valid_reg;

    assign inflight = OCC_W'(p1_valid_reg) + OCC_W'(p2_valid_reg)
                    + OCC_W'(p3_valid_reg) + OCC_W'(p4_valid_reg)
                    + OCC_W'(p5_valid_reg) + OCC_W'(p6_valid_reg);
    assign occupancy = OCC_W'(fifo_count_reg) + inflight;

    // every word in flight may need a queue slot
    assign s_tready = (int'(occupancy) < FIFO_DEPTH);

    logic in_accept;
    assign in_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // stage 1: input register
    // ------------------------------------------------------------------
    cmd_t              p1_cmd_reg;
    logic [COMP_W-1:0] p1_red_reg, p1_green_reg, p1_blue_reg;
    logic [SEL_W-1:0]  p1_sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p1_cmd_reg   <= cmd_t'(s_tuser);
            p1_red_reg   <= s_tdata[7:0];
            p1_green_reg <= s_tdata[15:8];
            p1_blue_reg  <= s_tdata[23:16];
            p1_sel_reg   <= s_tdata[31:24];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: weight products
    // ------------------------------------------------------------------
    cmd_t              p2_cmd_reg;
    logic [SEL_W-1:0]  p2_sel_reg;
    logic [PROD_W-1:0] p2_pr_reg, p2_pg_reg, p2_pb_reg;

    always_ff @(posedge clk)
    begin
        p2_cmd_reg <= p1_cmd_reg;
        p2_sel_reg <= p1_sel_reg;
        p2_pr_reg  <= PROD_W'(p1_red_reg) * PROD_W'(wred_reg);
        p2_pg_reg  <= PROD_W'(p1_green_reg) * PROD_W'(wgreen_reg);
        p2_pb_reg  <= PROD_W'(p1_blue_reg) * PROD_W'(wblue_reg);
    end

    // ------------------------------------------------------------------
    // stage 3: q10.16 gray sum scaled by levels-1
    // ------------------------------------------------------------------
    cmd_t                p3_cmd_reg;
    logic [SEL_W-1:0]    p3_sel_reg;
    logic [SCALED_W-1:0] p3_scaled_reg;
    logic [SUM_W-1:0]    gray_sum;

    assign gray_sum = SUM_W'(p2_pr_reg) + SUM_W'(p2_pg_reg) + SUM_W'(p2_pb_reg);

    always_ff @(posedge clk)
    begin
        p3_cmd_reg    <= p2_cmd_reg;
        p3_sel_reg    <= p2_sel_reg;
        p3_scaled_reg <= SCALED_W'(gray_sum) * SCALED_W'(top_bin);
    end

    // ------------------------------------------------------------------
    // stage 4: drop the fraction, reciprocal estimate of y / 255
    // ------------------------------------------------------------------
    cmd_t             p4_cmd_reg;
    logic [SEL_W-1:0] p4_sel_reg;
    logic [Y_W-1:0]   p4_y_reg;
    logic [Q_W-1:0]   p4_q0_reg;
    logic [Y_W-1:0]   y_val;
    logic [Y_W+8:0]   y_recip;

    assign y_val   = p3_scaled_reg[SCALED_W-1:FRAC_W];
    assign y_recip = (Y_W+9)'(y_val) * (Y_W+9)'(RECIP);

    always_ff @(posedge clk)
    begin
        p4_cmd_reg <= p3_cmd_reg;
        p4_sel_reg <= p3_sel_reg;
        p4_y_reg   <= y_val;
        // low by at most one
        p4_q0_reg  <= y_recip[Y_W+8:RECIP_SHIFT];
    end

    // ------------------------------------------------------------------
    // stage 5: correct the quotient, clamp, pick the address, read ram
    // ------------------------------------------------------------------
    cmd_t             p5_cmd_reg;
    logic [SEL_W-1:0] p5_sel_reg;
    bin_t             p5_addr_reg;
    logic             p5_in_range_reg;
    logic [Y_W-1:0]   div_rem;
    logic [Q_W-1:0]   quot;
    bin_t             pixel_bin;
    bin_t             addr_next;
    logic             in_range_next;

    always_comb
    begin
        div_rem = Y_W'(p4_y_reg - Y_W'(p4_q0_reg) * Y_W'(GRAY_DIV));
        quot    = p4_q0_reg;
        if (int'(div_rem) >= GRAY_DIV)
        begin
            quot = p4_q0_reg + Q_W'(1);
        end
        // bright pixels clamp to the top bin
        if (quot > Q_W'(top_bin))
        begin
            pixel_bin = top_bin;
        end
        else
        begin
            pixel_bin = BIN_W'(quot);
        end

        in_range_next = (int'(p4_sel_reg) < MAX_BINS);
        case (p4_cmd_reg)
            CMD_ADD:
            begin
                addr_next     = pixel_bin;
                in_range_next = 1'b1;
            end
            CMD_READ,
            CMD_READ_CLEAR:
            begin
                addr_next = in_range_next ? BIN_W'(p4_sel_reg) : '0;
            end
            default:
            begin
                addr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        p5_cmd_reg      <= p4_cmd_reg;
        p5_sel_reg      <= p4_sel_reg;
        p5_addr_reg     <= addr_next;
        p5_in_range_reg <= in_range_next;
    end

    // ------------------------------------------------------------------
    // counter ram, registered read
    // ------------------------------------------------------------------
    count_t count_mem [MAX_BINS];
    logic   cnt_valid_reg [MAX_BINS];
    count_t rdata_reg;
    logic   rvalid_reg;
    logic   mem_we;
    bin_t   mem_waddr;
    count_t mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            count_mem[mem_waddr] <= mem_wdata;
        end
        if (p5_valid_reg)
        begin
            rdata_reg <= count_mem[p5_addr_reg];
        end
    end

    // never-written bins read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BINS; i++)
            begin
                cnt_valid_reg[i] <= 1'b0;
            end
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                cnt_valid_reg[mem_waddr] <= 1'b1;
            end
            if (p5_valid_reg)
            begin
                rvalid_reg <= cnt_valid_reg[p5_addr_reg];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 6: read-modify-write with forwarding of the last write
    // ------------------------------------------------------------------
    cmd_t             p6_cmd_reg;
    logic [SEL_W-1:0] p6_sel_reg;
    bin_t             p6_addr_reg;
    logic             p6_in_range_reg;
    logic             fwd_valid_reg;
    bin_t             fwd_addr_reg;
    count_t           fwd_data_reg;
    count_t           cur_count;
    logic             fwd_hit;

    always_ff @(posedge clk)
    begin
        p6_cmd_reg      <= p5_cmd_reg;
        p6_sel_reg      <= p5_sel_reg;
        p6_addr_reg     <= p5_addr_reg;
        p6_in_range_reg <= p5_in_range_reg;
    end

    // the word ahead wrote at the same edge this one read
    assign fwd_hit   = fwd_valid_reg && (fwd_addr_reg == p6_addr_reg);
    assign cur_count = fwd_hit ? fwd_data_reg : (rvalid_reg ? rdata_reg : '0);
    assign mem_waddr = p6_addr_reg;

    always_comb
    begin
        mem_we     = 1'b0;
        mem_wdata  = '0;
        fifo_push  = 1'b0;
        fifo_wdata = {clip_count(cur_count), p6_sel_reg};
        case (p6_cmd_reg)
            CMD_ADD:
            begin
                mem_we    = p6_valid_reg;
                // saturate at full scale
                mem_wdata = (&cur_count) ? cur_count : cur_count + COUNT_WIDTH'(1);
            end
            CMD_READ:
            begin
                fifo_push = p6_valid_reg;
                if (!p6_in_range_reg)
                begin
                    fifo_wdata = {OUT_COUNT_W'(0), p6_sel_reg};
                end
            end
            CMD_READ_CLEAR:
            begin
                fifo_push = p6_valid_reg;
                mem_we    = p6_valid_reg && p6_in_range_reg;
                if (!p6_in_range_reg)
                begin
                    fifo_wdata = {OUT_COUNT_W'(0), p6_sel_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= mem_we;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= mem_waddr;
        fwd_data_reg <= mem_wdata;
    end

    // stage valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            p6_valid_reg <= 1'b0;
        end
        else
        begin
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
            p6_valid_reg <= p5_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    assign m_tvalid = (fifo_count_reg != '0);
    assign m_tdata  = fifo_mem[rd_ptr_reg];
    assign fifo_pop = m_tvalid && m_tready;

    assign fifo_count_next = fifo_count_reg + FIFO_CNT_W'(fifo_push)
                           - FIFO_CNT_W'(fifo_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_count_reg <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
        end
        else
        begin
            fifo_count_reg <= fifo_count_next;
            if (fifo_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (fifo_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_push)
        begin
            fifo_mem[wr_ptr_reg] <= fifo_wdata;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `RLH_ASSERT_NOW(a_queue_credit, 1'b1, int'(occupancy) <= FIFO_DEPTH)
    `RLH_ASSERT_NEXT(a_add_nonzero, p6_valid_reg && (p6_cmd_reg == CMD_ADD), fwd_valid_reg && (fwd_data_reg != '0))
    `RLH_ASSERT_NEXT(a_clear_zero, p6_valid_reg && (p6_cmd_reg == CMD_READ_CLEAR) && p6_in_range_reg, fwd_valid_reg && (fwd_data_reg == '0))

endmodule

`default_nettype wire

FILE: tb/rgb_luma_histogram_tb.sv
// self-checking testbench for the rgb luma histogram: directed script, then random phases
`default_nettype none

module rgb_luma_histogram_tb
    import rlh_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // command 3 has no member in cmd_t; the block must drop it silently
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    // the longest quiet stretch of a correct run is the receiver hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;
    // margin for the pipeline to empty before registers change
    localparam int SETTLE       = 16;
    localparam int PHASES       = 8;

    // one directed word; count is only meaningful when fixed is set
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       sel;
        logic             fixed;
        logic [31:0]      count;
    } probe_t;

    // a read result: bin number and its count
    typedef struct packed {
        logic [7:0]  bin;
        logic [31:0] count;
    } bin_read_t;

    // one register setting per phase: levels, red, green, blue weight, word count
    typedef struct packed {
        logic [LEVELS_W-1:0] levels;
        logic [WEIGHT_W-1:0] w_red;
        logic [WEIGHT_W-1:0] w_green;
        logic [WEIGHT_W-1:0] w_blue;
        logic [15:0]         words;
    } setting_t;

    // directed script, run at reset settings (levels 256, bt.601 weights)
    // white lands in bin 255 and black in bin 0, so those counts are typed in
    localparam probe_t SCRIPT [22] = '{
        '{CMD_READ,       8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 32'd0},  // empty after reset
        '{CMD_READ_CLEAR, 8'd0,   8'd0,   8'd0,   8'd255, 1'b1, 32'd0},
        '{CMD_ADD,        8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 32'd0},  // black
        '{CMD_ADD,        8'd255, 8'd255, 8'd255, 8'd0,   1'b0, 32'd0},  // white
        '{CMD_ADD,        8'd255, 8'd255, 8'd255, 8'd170, 1'b0, 32'd0},
        '{CMD_READ,       8'd0,   8'd0,   8'd0,   8'd255, 1'b1, 32'd2},
        '{CMD_READ_CLEAR, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 32'd1},
        '{CMD_READ,       8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 32'd0},  // cleared
        '{CMD_READ_CLEAR, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 32'd2},
        '{CMD_READ,       8'd0,   8'd0,   8'd0,   8'd255, 1'b1, 32'd0},
        '{CMD_UNKNOWN,    8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 32'd0},  // dropped
        '{CMD_READ,       8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 32'd0},  // nothing added
        '{CMD_ADD,        8'd255, 8'd0,   8'd0,   8'd85,  1'b0, 32'd0},  // pure red
        '{CMD_ADD,        8'd0,   8'd255, 8'd0,   8'd0,   1'b0, 32'd0},  // pure green
        '{CMD_ADD,        8'd0,   8'd0,   8'd255, 8'd0,   1'b0, 32'd0},  // pure blue
        '{CMD_ADD,        8'd1,   8'd1,   8'd1,   8'd0,   1'b0, 32'd0},  // darkest gray
        '{CMD_ADD,        8'd128, 8'd64,  8'd32,  8'd0,   1'b0, 32'd0},
        '{CMD_READ,       8'd0,   8'd0,   8'd0,   8'd76,  1'b0, 32'd0},
        '{CMD_READ,       8'd0,   8'd0,   8'd0,   8'd149, 1'b0, 32'd0},
        '{CMD_READ_CLEAR, 8'd0,   8'd0,   8'd0,   8'd29,  1'b0, 32'd0},
        '{CMD_READ,       8'd0,   8'd0,   8'd0,   8'd1,   1'b0, 32'd0},
        '{CMD_READ,       8'd0,   8'd0,   8'd0,   8'd200, 1'b0, 32'd0}
    };

    // phase settings; phase 0 keeps reset values, phase 6 is drawn at random
    // phase 1: zero levels with bright weights, phase 2: levels above storage
    // with bright weights (clamp) and the receiver hold-off
    localparam setting_t PHASE_SET [PHASES] = '{
        '{9'd256, 16'd19595, 16'd38470, 16'd7471,  16'd60},
        '{9'd0,   16'd65535, 16'd65535, 16'd65535, 16'd60},
        '{9'd511, 16'd65535, 16'd65535, 16'd65535, 16'd120},
        '{9'd2,   16'd0,     16'd0,     16'd0,     16'd50},
        '{9'd1,   16'd40000, 16'd20000, 16'd5000,  16'd50},
        '{9'd256, 16'd21845, 16'd21845, 16'd21845, 16'd60},
        '{9'd128, 16'd0,     16'd0,     16'd0,     16'd60},
        '{9'd3,   16'd32768, 16'd16384, 16'd16384, 16'd50}
    };

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;   // red, green, blue, bin_select
    logic [CMD_W-1:0]      s_tuser  = '0;   // command
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;         // bin_number, bin_count
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predicted block state: counters and register copies
    count_t              bin_counts [MAX_BINS];
    logic [LEVELS_W-1:0] levels_reg  = LEVELS_RESET;
    logic [WEIGHT_W-1:0] w_red_reg   = WRED_RESET;
    logic [WEIGHT_W-1:0] w_green_reg = WGREEN_RESET;
    logic [WEIGHT_W-1:0] w_blue_reg  = WBLUE_RESET;

    bin_read_t pending_reads [$];   // read results still to arrive, oldest first
    int        err_count   = 0;
    int        burst_left  = 0;     // words left in the current sender burst
    bit        hold_go     = 1'b0;  // asks the receiver for its long hold-off

    rgb_luma_histogram u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // levels actually in use: 0 acts as 1, anything above storage as MAX_BINS
    function automatic int active_levels();
        int lv;
        lv = int'(levels_reg);
        if (lv < 1)
            lv = 1;
        if (lv > MAX_BINS)
            lv = MAX_BINS;
        return lv;
    endfunction

    // gray sum is q10.16; bin = floor(sum * (levels-1) / (255 * 2^16)), clamped
    function automatic int luma_bin(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [63:0] gray;
        logic [63:0] q;
        logic [63:0] top;
        top  = 64'(active_levels() - 1);
        gray = 64'(r) * 64'(w_red_reg) + 64'(g) * 64'(w_green_reg)
             + 64'(b) * 64'(w_blue_reg);
        q    = (gray * top) / (64'd255 * 64'd65536);
        if (q > top)
            q = top;
        return int'(q);
    endfunction

    // update predicted state for an accepted word, queue the read result if any
    task automatic take_word(input logic [CMD_W-1:0] cmd, input logic [S_DATA_W-1:0] data,
                             input logic fixed, input logic [31:0] fixed_count);
        int        b;
        bin_read_t rd;
        case (cmd)
            CMD_ADD:
            begin
                b = luma_bin(data[7:0], data[15:8], data[23:16]);
                if (bin_counts[b] != '1)
                    bin_counts[b] = bin_counts[b] + 1'b1;
            end
            CMD_READ, CMD_READ_CLEAR:
            begin
                // bin_select is 8 bits, so it always lies inside 256-bin storage
                rd.bin   = data[31:24];
                rd.count = fixed ? fixed_count : 32'(bin_counts[rd.bin]);
                pending_reads.push_back(rd);
                if (cmd == CMD_READ_CLEAR)
                    bin_counts[rd.bin] = '0;
            end
            default:
            begin
                // unknown command: no state change, no result
            end
        endcase
    endtask

    // offer one word and hold it until accepted; bursts end in a random gap
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [S_DATA_W-1:0] data,
                             input logic fixed, input logic [31:0] fixed_count);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            // mostly short bursts, now and then a long unbroken run
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        take_word(cmd, data, fixed, fixed_count);
    endtask

    // apb write: setup cycle, access cycle, then idle with psel low
    task automatic write_reg(input reg_index_t idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // register takes the value at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LEVELS:       levels_reg  = value[LEVELS_W-1:0];
            REG_WEIGHT_RED:   w_red_reg   = value[WEIGHT_W-1:0];
            REG_WEIGHT_GREEN: w_green_reg = value[WEIGHT_W-1:0];
            default:          w_blue_reg  = value[WEIGHT_W-1:0];
        endcase
        @(posedge clk);
    endtask

    // stop offering, wait for every read result, then let the pipe empty
    task automatic drain();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // main sequence: reset, directed script, random phases, final verdict
    initial
    begin : main_seq
        int                  p;
        int                  i;
        int                  pick;
        int                  lv;
        setting_t            cfg;
        logic [CMD_W-1:0]    cmd;
        logic [7:0]          sel;

        for (i = 0; i < MAX_BINS; i++)
            bin_counts[i] = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed script at reset settings
        for (i = 0; i < $size(SCRIPT); i++)
            send_word(SCRIPT[i].cmd,
                      {SCRIPT[i].sel, SCRIPT[i].blue, SCRIPT[i].green, SCRIPT[i].red},
                      SCRIPT[i].fixed, SCRIPT[i].count);

        for (p = 0; p < PHASES; p++)
        begin
            cfg = PHASE_SET[p];
            if (p == 6)
            begin
                cfg.levels  = LEVELS_W'($urandom_range(1, MAX_BINS));
                cfg.w_red   = WEIGHT_W'($urandom);
                cfg.w_green = WEIGHT_W'($urandom);
                cfg.w_blue  = WEIGHT_W'($urandom);
            end
            // registers change only with the block idle
            if (p > 0)
            begin
                drain();
                write_reg(REG_LEVELS,       APB_DATA_W'(cfg.levels));
                write_reg(REG_WEIGHT_RED,   APB_DATA_W'(cfg.w_red));
                write_reg(REG_WEIGHT_GREEN, APB_DATA_W'(cfg.w_green));
                write_reg(REG_WEIGHT_BLUE,  APB_DATA_W'(cfg.w_blue));
            end
            // long receiver hold-off while words keep coming, fills the result queue
            if (p == 2)
                hold_go = 1'b1;

            lv = active_levels();
            for (i = 0; i < int'(cfg.words); i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 62)
                    cmd = CMD_ADD;
                else if (pick < 80)
                    cmd = CMD_READ;
                else if (pick < 96)
                    cmd = CMD_READ_CLEAR;
                else
                    cmd = CMD_UNKNOWN;
                // most reads hit bins in use, the rest roam all 256 bins
                sel = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, lv - 1))
                                                  : 8'($urandom);
                send_word(cmd, {sel, 24'($urandom)}, 1'b0, '0);
            end
        end

        drain();
        if (err_count == 0)
            $display("[rgb_luma_histogram] OK");
        else
            $display("[rgb_luma_histogram] ERROR");
        $finish;
    end

    // receiver: stall pattern is redrawn whenever its tick counter runs out, plus one hold-off
    initial
    begin : receiver
        int mode;
        int tick;
        bit hold_done;
        mode      = 0;
        tick      = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (tick == 0)
                begin
                    mode = $urandom_range(0, 3);
                    tick = $urandom_range(8, 48);
                end
                tick--;
                case (mode)
                    0:       m_tready <= 1'b1;                          // always ready
                    1:       m_tready <= 1'($urandom_range(0, 1));      // coin flip
                    2:       m_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
                    default: m_tready <= (tick % 3 == 0);               // ready when tick is a multiple of three
                endcase
            end
        end
    end

    // result checker: each read word against the oldest queued expectation
    always @(posedge clk)
    begin : result_check
        bin_read_t exp_rd;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reads.size() == 0)
            begin
                $error("unexpected result word: bin_number %0d bin_count %0d",
                       m_tdata[7:0], m_tdata[39:8]);
                err_count++;
            end
            else
            begin
                exp_rd = pending_reads.pop_front();
                if (m_tdata[7:0] !== exp_rd.bin)
                begin
                    $error("bin_number: expected %0d, got %0d", exp_rd.bin, m_tdata[7:0]);
                    err_count++;
                end
                if (m_tdata[39:8] !== exp_rd.count)
                begin
                    $error("bin_count: expected %0d, got %0d", exp_rd.count, m_tdata[39:8]);
                    err_count++;
                end
            end
        end
    end

    // watchdog: too many cycles with no word moving on any port ends the run
    always @(posedge clk)
    begin : watchdog
        int idle_cycles;
        if (!rst_n)
            idle_cycles = 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[rgb_luma_histogram] ERROR");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hw/rtl
hw/rtl/rlh_pkg.sv
hw/rtl/rgb_luma_histogram.sv
tb/rgb_luma_histogram_tb.sv
